// File: rtl/core/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// shared types, constants and helpers of the utf-8 stream decoder
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int CP_W  = 31;
    localparam int REM_W = 3;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CP_W-1:0] REPL_CHAR = CP_W'(32'h0000_FFFD);

    // byte class boundaries
    localparam logic [7:0] CONT_BASE  = 8'h80;
    localparam logic [7:0] LEAD2_BASE = 8'hC0;
    localparam logic [7:0] LEAD3_BASE = 8'hE0;
    localparam logic [7:0] LEAD4_BASE = 8'hF0;
    localparam logic [7:0] LEAD5_BASE = 8'hF8;
    localparam logic [7:0] LEAD6_BASE = 8'hFC;
    localparam logic [7:0] BAD_BASE   = 8'hFE;
    localparam logic [5:0] CONT_MASK  = 6'h3F;

    // one queue entry: up to two results caused by one input item
    typedef struct packed {
        logic            two;
        logic [CP_W-1:0] cp0;
        logic            bad0;
        logic [CP_W-1:0] cp1;
        logic            bad1;
    } u8sd_entry_t;

    // least legal value by total sequence length
    function automatic logic [CP_W-1:0] least_value(input logic [REM_W-1:0] len);
        logic [CP_W-1:0] v;
        begin
            unique case (len)
                3'd2:    v = CP_W'(32'h0000_0080);
                3'd3:    v = CP_W'(32'h0000_0800);
                3'd4:    v = CP_W'(32'h0001_0000);
                3'd5:    v = CP_W'(32'h0020_0000);
                3'd6:    v = CP_W'(32'h0400_0000);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: rtl/core/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// byte-serial decoder for six-byte legacy utf-8, code points up to 0x7fffffff
// ----------------------------------------------------------------------------
// Takes one byte item per cycle and gives code point items. A front stage
// classifies each byte against the pending sequence and forms the zero, one
// or two results it causes; these wait in a short queue (QUEUE_DEPTH entries)
// and a back stage hands them out one result item per cycle, unless stalled,
// through an output register. Input is taken every cycle while the queue has
// room, so the input rate is one byte per cycle; the output side moves one
// result per cycle, so a byte that breaks a sequence and yields two results
// holds the back stage for both, and the input stalls only once the queue
// has filled. Results pass a queue slot, then the output register. Malformed
// input yields 0xFFFD with bad_sequence set; last_of_run marks the final
// result of each byte. A lead byte opening a sequence gives none of its own.
module utf8_stream_decoder
#(
    parameter int QUEUE_DEPTH = u8sd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // byte input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                data_byte,
    input  logic                      end_of_text,
    // result output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [u8sd_pkg::CP_W-1:0] code_point,
    output logic                      bad_sequence,
    output logic                      last_of_run
);
    import u8sd_pkg::*;

    // front to queue
    logic        push;
    u8sd_entry_t push_entry;
    logic        q_full;

    // queue to back
    logic        q_valid;
    u8sd_entry_t q_head;
    logic        pop;

    // classify bytes and track the pending sequence
    u8sd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .end_of_text(end_of_text),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples the byte side from the result side
    u8sd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // one result item per cycle unless stalled, split of two-result entries
    u8sd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .bad_sequence(bad_sequence),
        .last_of_run (last_of_run)
    );

endmodule

// File: rtl/core/u8sd_front.sv
// ----------------------------------------------------------------------------
// u8sd_front
// accepts bytes, tracks the pending sequence and forms the results of a byte
// ----------------------------------------------------------------------------
module u8sd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_text,
    input  logic                 q_full,
    output logic                 push,
    output u8sd_pkg::u8sd_entry_t push_entry
);
    import u8sd_pkg::*;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] len_reg, len_next;
    logic [CP_W-1:0]  part_reg, part_next;

    logic             accept;
    logic             is_cont;
    logic             handled;
    logic             over;
    logic [1:0]       n;
    logic [CP_W-1:0]  res_cp;
    logic             res_bad;
    logic             res_en;
    logic [REM_W-1:0] lead_rem;
    logic [CP_W-1:0]  lead_bits;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_cont  = (data_byte >= CONT_BASE) && (data_byte < LEAD2_BASE);

    // continuation count and payload bits of a lead byte
    always_comb
    begin
        priority if (data_byte < LEAD3_BASE)
        begin
            lead_rem  = 3'd1;
            lead_bits = CP_W'(data_byte[4:0]);
        end
        else if (data_byte < LEAD4_BASE)
        begin
            lead_rem  = 3'd2;
            lead_bits = CP_W'(data_byte[3:0]);
        end
        else if (data_byte < LEAD5_BASE)
        begin
            lead_rem  = 3'd3;
            lead_bits = CP_W'(data_byte[2:0]);
        end
        else if (data_byte < LEAD6_BASE)
        begin
            lead_rem  = 3'd4;
            lead_bits = CP_W'(data_byte[1:0]);
        end
        else
        begin
            lead_rem  = 3'd5;
            lead_bits = CP_W'(data_byte[0]);
        end
    end

    always_comb
    begin
        rem_next   = rem_reg;
        len_next   = len_reg;
        part_next  = part_reg;
        push_entry = '0;
        n          = 2'd0;
        handled    = 1'b0;
        over       = 1'b0;

        // pending sequence: continue, finish or break it
        if (rem_reg != '0)
        begin
            if (is_cont)
            begin
                part_next = {part_reg[CP_W-7:0], data_byte[5:0] & CONT_MASK};
                rem_next  = rem_reg - 3'd1;
                handled   = 1'b1;
                if (rem_next == '0)
                begin
                    over            = part_next < least_value(len_reg);
                    push_entry.cp0  = over ? REPL_CHAR : part_next;
                    push_entry.bad0 = over;
                    n               = 2'd1;
                    part_next       = '0;
                    len_next        = '0;
                end
            end
            else
            begin
                push_entry.cp0  = REPL_CHAR;
                push_entry.bad0 = 1'b1;
                n               = 2'd1;
                rem_next        = '0;
                part_next       = '0;
                len_next        = '0;
            end
        end

        // byte decoded from idle
        res_en  = 1'b0;
        res_cp  = REPL_CHAR;
        res_bad = 1'b1;
        if (!handled)
        begin
            if (data_byte < CONT_BASE)
            begin
                res_en  = 1'b1;
                res_cp  = CP_W'(data_byte);
                res_bad = 1'b0;
            end
            else if (is_cont || (data_byte >= BAD_BASE))
            begin
                res_en = 1'b1;
            end
            else
            begin
                rem_next  = lead_rem;
                len_next  = lead_rem + 3'd1;
                part_next = lead_bits;
            end
        end
        if (res_en)
        begin
            if (n == 2'd0)
            begin
                push_entry.cp0  = res_cp;
                push_entry.bad0 = res_bad;
            end
            else
            begin
                push_entry.cp1  = res_cp;
                push_entry.bad1 = res_bad;
                push_entry.two  = 1'b1;
            end
            n = n + 2'd1;
        end

        // end of text flushes a pending sequence
        if (end_of_text && (rem_next != '0))
        begin
            if (n == 2'd0)
            begin
                push_entry.cp0  = REPL_CHAR;
                push_entry.bad0 = 1'b1;
            end
            else
            begin
                push_entry.cp1  = REPL_CHAR;
                push_entry.bad1 = 1'b1;
                push_entry.two  = 1'b1;
            end
            n         = n + 2'd1;
            rem_next  = '0;
            part_next = '0;
            len_next  = '0;
        end

        push = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            len_reg  <= '0;
            part_reg <= '0;
        end
        else if (accept)
        begin
            rem_reg  <= rem_next;
            len_reg  <= len_next;
            part_reg <= part_next;
        end
    end

endmodule

// File: rtl/core/u8sd_queue.sv
// ----------------------------------------------------------------------------
// u8sd_queue
// short fifo of result entries between front and back
// ----------------------------------------------------------------------------
module u8sd_queue
#(
    parameter int DEPTH = u8sd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u8sd_pkg::u8sd_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output u8sd_pkg::u8sd_entry_t head
);
    import u8sd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u8sd_entry_t       slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/core/u8sd_back.sv
// ----------------------------------------------------------------------------
// u8sd_back
// drains queue entries and presents one result item a cycle unless stalled
// ----------------------------------------------------------------------------
module u8sd_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  u8sd_pkg::u8sd_entry_t       q_head,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [u8sd_pkg::CP_W-1:0]   code_point,
    output logic                        bad_sequence,
    output logic                        last_of_run
);
    import u8sd_pkg::*;

    logic            out_valid_reg, out_valid_next;
    logic            sel_reg, sel_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic            bad_reg, bad_next;
    logic            last_reg, last_next;
    logic            load;
    logic            take;
    logic            split;

    always_comb
    begin
        load  = !out_valid_reg || !out_stall;
        take  = load && q_valid;
        split = q_head.two && !sel_reg;
        pop   = take && !split;

        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        cp_next        = cp_reg;
        bad_next       = bad_reg;
        last_next      = last_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            sel_next       = split;
            cp_next        = sel_reg ? q_head.cp1 : q_head.cp0;
            bad_next       = sel_reg ? q_head.bad1 : q_head.bad0;
            last_next      = !split;
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        bad_reg  <= bad_next;
        last_reg <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign code_point   = cp_reg;
    assign bad_sequence = bad_reg;
    assign last_of_run  = last_reg;

endmodule

// File: bench/utf8_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// self-checking bench for the byte-serial six-byte utf-8 decoder
// ----------------------------------------------------------------------------
// A driver offers byte items from a queue that the stimulus block fills: a
// short directed list first, then random well-formed sequences mixed with
// noise and cut-short sequences. Every accepted byte runs through a local
// decoder model that queues the code points it should cause. A monitor takes
// result items and checks each field against the oldest expected one. Both
// sides idle in short random bursts, the receiver holds off once for a long
// stretch so the input backs up, and the sender waits twice for a full drain.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;

    import u8sd_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int TAIL_ITEMS   = 80;    // no idling once this few bytes remain
    localparam int HOLD_AT      = 150;   // result count that starts the long hold
    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE       = 20;    // quiet cycles after the last result
    localparam int STUCK_LIMIT  = 1000;  // cycles with no handshake at all

    // one byte item waiting to be offered; drain holds it back until idle
    typedef struct {
        logic [7:0] data;
        logic       eot;
        logic       drain;
    } byte_item_t;

    // one decoded result as the block should present it
    typedef struct {
        logic [CP_W-1:0] cp;
        logic            bad;
        logic            last;
    } cp_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [7:0]      data_byte = 8'h00;
    logic            end_of_text = 1'b0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [CP_W-1:0] code_point;
    logic            bad_sequence;
    logic            last_of_run;

    byte_item_t byte_q[$];
    cp_result_t cp_expect[$];
    int         mismatches = 0;

    // decoder model state
    logic [2:0]      cont_left = '0;
    logic [CP_W-1:0] gathered  = '0;
    logic [2:0]      seq_len   = '0;

    utf8_stream_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_point   (code_point),
        .bad_sequence (bad_sequence),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
        begin
            $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got_v,
                     want_v);
            mismatches++;
        end
    endtask

    // decode one accepted byte and queue the zero, one or two results it causes
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        cp_result_t      res[$];
        cp_result_t      r;
        logic            taken;
        logic [CP_W-1:0] floor_v;
        logic [2:0]      n;
        begin
            taken = 1'b0;
            r.last = 1'b0;
            if (cont_left != 0) begin
                if (b >= CONT_BASE && b < LEAD2_BASE) begin
                    gathered = {gathered[CP_W-7:0], b[5:0]};
                    cont_left = cont_left - 3'd1;
                    if (cont_left == 0) begin
                        // least value that a sequence of this length may carry
                        case (seq_len)
                            3'd2:    floor_v = CP_W'(32'h0000_0080);
                            3'd3:    floor_v = CP_W'(32'h0000_0800);
                            3'd4:    floor_v = CP_W'(32'h0001_0000);
                            3'd5:    floor_v = CP_W'(32'h0020_0000);
                            3'd6:    floor_v = CP_W'(32'h0400_0000);
                            default: floor_v = '0;
                        endcase
                        r.bad = (gathered < floor_v);
                        r.cp  = r.bad ? REPL_CHAR : gathered;
                        res = {res, r};
                        cont_left = '0;
                        gathered  = '0;
                        seq_len   = '0;
                    end
                    taken = 1'b1;
                end
                else begin
                    // sequence broken: replace it, then decode the byte afresh
                    r.cp = REPL_CHAR;
                    r.bad = 1'b1;
                    res = {res, r};
                    cont_left = '0;
                    gathered  = '0;
                    seq_len   = '0;
                end
            end
            if (!taken) begin
                if (b < CONT_BASE) begin
                    r.cp = CP_W'(b);
                    r.bad = 1'b0;
                    res = {res, r};
                end
                else if (b < LEAD2_BASE || b >= BAD_BASE) begin
                    r.cp = REPL_CHAR;
                    r.bad = 1'b1;
                    res = {res, r};
                end
                else begin
                    if (b < LEAD3_BASE)      n = 3'd1;
                    else if (b < LEAD4_BASE) n = 3'd2;
                    else if (b < LEAD5_BASE) n = 3'd3;
                    else if (b < LEAD6_BASE) n = 3'd4;
                    else                     n = 3'd5;
                    cont_left = n;
                    seq_len   = n + 3'd1;
                    gathered  = CP_W'(b & ((8'd1 << (6 - n)) - 8'd1));
                end
            end
            if (eot && cont_left != 0) begin
                r.cp = REPL_CHAR;
                r.bad = 1'b1;
                res = {res, r};
                cont_left = '0;
                gathered  = '0;
                seq_len   = '0;
            end
            if (res.size() > 0)
                res[res.size()-1].last = 1'b1;
            foreach (res[i])
                cp_expect = {cp_expect, res[i]};
        end
    endtask

    task automatic add_item(input logic [7:0] b, input logic eot,
                            input logic drain = 1'b0);
        byte_item_t it;
        begin
            it.data  = b;
            it.eot   = eot;
            it.drain = drain;
            byte_q = {byte_q, it};
        end
    endtask

    // lead byte of a sequence of len bytes, random payload bits
    function automatic logic [7:0] random_lead(input int len);
        logic [7:0] b;
        begin
            case (len)
                1:       b = 8'($urandom_range(0, 127));
                2:       b = LEAD2_BASE | 8'($urandom_range(0, 31));
                3:       b = LEAD3_BASE | 8'($urandom_range(0, 15));
                4:       b = LEAD4_BASE | 8'($urandom_range(0, 7));
                5:       b = LEAD5_BASE | 8'($urandom_range(0, 3));
                default: b = LEAD6_BASE | 8'($urandom_range(0, 1));
            endcase
            return b;
        end
    endfunction

    // stimulus and end of run
    initial
    begin : stim
        int added;
        int pick;
        int len;
        int cut;
        int drains;
        logic eot_pick;

        // ascii extremes, nul included
        add_item(8'h00, 1'b0);
        add_item(8'h7F, 1'b0);
        // stray continuation and the two invalid leads
        add_item(8'h80, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'hFE, 1'b0);
        // two-byte form, then an overlong one
        add_item(8'hC2, 1'b0);
        add_item(8'hA9, 1'b0);
        add_item(8'hC0, 1'b0);
        add_item(8'h80, 1'b0);
        // six-byte form at the top of the range
        add_item(8'hFD, 1'b0);
        repeat (5) add_item(8'hBF, 1'b0);
        // interrupted by ascii, then by an invalid lead: two results each
        add_item(8'hE2, 1'b0);
        add_item(8'h41, 1'b0);
        add_item(8'hF8, 1'b0);
        add_item(8'hFE, 1'b0);
        // end of text on a lead byte, mid sequence, and on plain ascii
        add_item(8'hC3, 1'b1);
        add_item(8'hF0, 1'b0);
        add_item(8'h9F, 1'b1);
        add_item(8'h41, 1'b1);
        // three-byte form
        add_item(8'hE2, 1'b0);
        add_item(8'h82, 1'b0);
        add_item(8'hAC, 1'b0);

        // random part: mostly well-formed sequences, some noise and cut-offs
        added = 0;
        drains = 0;
        while (added < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            len  = $urandom_range(1, 6);
            if (pick < 7 || (pick == 7 && len == 1)) begin
                eot_pick = ($urandom_range(0, 7) == 0);
                for (int k = 0; k < len; k++) begin
                    add_item(k == 0 ? random_lead(len) : CONT_BASE | 8'($urandom_range(0, 63)),
                             (k == len - 1) ? eot_pick : 1'b0,
                             (k == 0 && (added == 0 || (added >= 400 && drains == 1))));
                    if (k == 0 && (added == 0 || (added >= 400 && drains == 1)))
                        drains++;
                    added++;
                end
            end
            else if (pick == 7) begin
                // cut short, either by end of text or by whatever follows
                cut = $urandom_range(1, len - 1);
                eot_pick = ($urandom_range(0, 2) == 0);
                for (int k = 0; k < cut; k++) begin
                    add_item(k == 0 ? random_lead(len) : CONT_BASE | 8'($urandom_range(0, 63)),
                             (k == cut - 1) ? eot_pick : 1'b0);
                    added++;
                end
            end
            else begin
                repeat ($urandom_range(1, 3)) begin
                    add_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
                    added++;
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // all bytes taken and every result seen, then a few quiet cycles
        @(posedge clk);
        while (byte_q.size() != 0 || in_valid || cp_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // driver: one byte item per handshake, random idle bursts
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic       nv;
        byte_item_t it;
        int         gap_left;
        logic       idle_en;
        if (!rst_n) begin
            in_valid    <= 1'b0;
            data_byte   <= 8'h00;
            end_of_text <= 1'b0;
            gap_left = 0;
            idle_en  = 1'b1;
        end
        else begin
            if (in_valid && !in_stall)
                decode_byte(data_byte, end_of_text);
            if ($urandom_range(0, 47) == 0)
                idle_en = !idle_en;
            // a stalled item stays on the port unchanged
            if (!(in_valid && in_stall)) begin
                nv = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (byte_q.size() == 0)
                    nv = 1'b0;
                else if (byte_q[0].drain && cp_expect.size() != 0)
                    nv = 1'b0;
                else if (idle_en && byte_q.size() >= TAIL_ITEMS
                         && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(0, 2);
                else begin
                    it = byte_q.pop_front();
                    data_byte   <= it.data;
                    end_of_text <= it.eot;
                    nv = 1'b1;
                end
                in_valid <= nv;
            end
        end
    end

    // monitor: checks each result item, drives the receiver stall
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        cp_result_t want;
        logic       ns;
        int         results_seen;
        int         hold_left;
        int         stall_left;
        logic       hold_done;
        logic       idle_en;
        if (!rst_n) begin
            out_stall <= 1'b0;
            results_seen = 0;
            hold_left    = 0;
            stall_left   = 0;
            hold_done    = 1'b0;
            idle_en      = 1'b1;
        end
        else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (cp_expect.size() == 0)
                    flag_mismatch("unexpected result, code_point", 32'(code_point), 32'h0);
                else begin
                    want = cp_expect.pop_front();
                    if (code_point !== want.cp)
                        flag_mismatch("code_point", 32'(code_point), 32'(want.cp));
                    if (bad_sequence !== want.bad)
                        flag_mismatch("bad_sequence", 32'(bad_sequence), 32'(want.bad));
                    if (last_of_run !== want.last)
                        flag_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
                end
            end
            if ($urandom_range(0, 47) == 0)
                idle_en = !idle_en;
            ns = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
                ns = 1'b1;
            end
            else if (!hold_done && results_seen >= HOLD_AT) begin
                // long hold so the internal queue fills and the input stalls
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                ns = 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                ns = 1'b1;
            end
            else if (idle_en && byte_q.size() >= TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 2);
                ns = 1'b1;
            end
            out_stall <= ns;
        end
    end

    // watchdog: ends a run that has stopped moving
    always @(posedge clk)
    begin : dog_proc
        int quiet;
        if (!rst_n)
            quiet = 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else begin
            quiet++;
            if (quiet >= STUCK_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", quiet);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
